FILE: rtl/sha256_pkg.sv
// Shared types and constants for the SHA-256 stream hasher.
// Holds the transaction structs, command queue types, state codes and round tables.
// No dependencies.
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_BYTE_END,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_ZERO,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } core_state_t;

    typedef enum logic [1:0] {
        AFTER_IDLE,
        AFTER_MARK,
        AFTER_ZERO,
        AFTER_EMIT
    } after_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

FILE: rtl/sha256_front.sv
// Input stage of the SHA-256 stream hasher: accepts transactions and turns them into commands.
// Depends on sha256_pkg.
module sha256_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sha256_pkg::in_item_t  s_item,
    input  sha256_pkg::q_status_t q_status,
    output sha256_pkg::q_push_t   q_push
);
    import sha256_pkg::*;

    logic accepted;

    assign s_ready  = !q_status.full;
    assign accepted = s_valid && s_ready;

    // A transaction with neither a byte nor an end of message is dropped here.
    always_comb begin
        q_push.valid    = accepted && (s_item.byte_valid || s_item.end_of_message);
        q_push.cmd.data = s_item.data_byte;
        if (s_item.byte_valid && s_item.end_of_message) begin
            q_push.cmd.kind = CMD_BYTE_END;
        end else if (s_item.byte_valid) begin
            q_push.cmd.kind = CMD_BYTE;
        end else begin
            q_push.cmd.kind = CMD_END;
        end
    end

endmodule

FILE: rtl/sha256_queue.sv
// Short command queue between the input stage and the hash core.
// Depends on sha256_pkg.
module sha256_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sha256_pkg::q_push_t   q_push,
    input  logic                  q_pop,
    output sha256_pkg::cmd_t      q_head,
    output sha256_pkg::q_status_t q_status
);
    import sha256_pkg::*;

    cmd_t                   entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign q_status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign q_head         = entries_reg[rd_ptr_reg];

    assign do_push = q_push.valid && !q_status.full;
    assign do_pop  = q_pop && !q_status.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= q_push.cmd;
        end
    end

endmodule

FILE: rtl/sha256_core.sv
// Hash core: block buffer, padding sequencer, 64-round compression and digest output.
// Depends on sha256_pkg.
module sha256_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sha256_pkg::cmd_t      q_head,
    input  sha256_pkg::q_status_t q_status,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sha256_pkg::out_item_t m_item
);
    import sha256_pkg::*;

    core_state_t state_reg, state_next;
    after_t      after_reg, after_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  emit_idx_reg, emit_idx_next;
    logic [31:0] hash_reg [8];
    logic [31:0] hash_next [8];
    logic [31:0] work_reg [8];
    logic [31:0] work_next [8];
    logic [31:0] sched_reg [16];
    logic [31:0] sched_next [16];

    logic        head_has_byte;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] sched_new;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    assign head_has_byte = (q_head.kind == CMD_BYTE) || (q_head.kind == CMD_BYTE_END);

    assign t1 = work_reg[7] + big_sigma1(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + ROUND_K[round_reg] + sched_reg[0];
    assign t2 = big_sigma0(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]));
    assign sched_new = small_sigma1(sched_reg[14]) + sched_reg[9]
                     + small_sigma0(sched_reg[1]) + sched_reg[0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    if (head_has_byte && fill_reg == LAST_POS) begin
                        state_next = ST_ROUND;
                    end else if (q_head.kind != CMD_BYTE) begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                state_next = (fill_reg == LAST_POS) ? ST_ROUND : ST_ZERO;
            end
            ST_ZERO: begin
                if (fill_reg == LENGTH_POS || fill_reg == LAST_POS) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (round_reg == 6'd63) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                unique case (after_reg)
                    AFTER_IDLE: state_next = ST_IDLE;
                    AFTER_MARK: state_next = ST_MARK;
                    AFTER_ZERO: state_next = ST_ZERO;
                    AFTER_EMIT: state_next = ST_EMIT;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_EMIT: begin
                if (m_ready && emit_idx_reg == 3'd7) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop               = (state_reg == ST_IDLE) && !q_status.empty;
        m_valid             = (state_reg == ST_EMIT);
        m_item.digest_word  = hash_reg[0];
        m_item.word_index   = emit_idx_reg;
        m_item.last_word    = (emit_idx_reg == 3'd7);
    end

    always_comb begin
        after_next    = after_reg;
        fill_next     = fill_reg;
        bits_next     = bits_reg;
        round_next    = round_reg;
        emit_idx_next = emit_idx_reg;
        hash_next     = hash_reg;
        work_next     = work_reg;
        sched_next    = sched_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty && head_has_byte) begin
                    sched_next[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] = q_head.data;
                    fill_next = fill_reg + 6'd1;
                    bits_next = bits_reg + 64'd8;
                    if (fill_reg == LAST_POS) begin
                        after_next = (q_head.kind == CMD_BYTE_END) ? AFTER_MARK : AFTER_IDLE;
                        work_next  = hash_reg;
                        round_next = '0;
                    end
                end
            end
            ST_MARK: begin
                sched_next[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] = PAD_MARK;
                fill_next = fill_reg + 6'd1;
                if (fill_reg == LAST_POS) begin
                    after_next = AFTER_ZERO;
                    work_next  = hash_reg;
                    round_next = '0;
                end
            end
            ST_ZERO: begin
                if (fill_reg == LENGTH_POS) begin
                    sched_next[14] = bits_reg[63:32];
                    sched_next[15] = bits_reg[31:0];
                    fill_next      = '0;
                    after_next     = AFTER_EMIT;
                    work_next      = hash_reg;
                    round_next     = '0;
                end else begin
                    sched_next[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] = 8'h00;
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == LAST_POS) begin
                        after_next = AFTER_ZERO;
                        work_next  = hash_reg;
                        round_next = '0;
                    end
                end
            end
            ST_ROUND: begin
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                for (int i = 0; i < 15; i++) begin
                    sched_next[i] = sched_reg[i + 1];
                end
                sched_next[15] = sched_new;
                round_next     = round_reg + 6'd1;
            end
            ST_UPDATE: begin
                for (int i = 0; i < 8; i++) begin
                    hash_next[i] = hash_reg[i] + work_reg[i];
                end
                emit_idx_next = '0;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    for (int i = 0; i < 7; i++) begin
                        hash_next[i] = hash_reg[i + 1];
                    end
                    hash_next[7]  = hash_reg[0];
                    emit_idx_next = emit_idx_reg + 3'd1;
                    if (emit_idx_reg == 3'd7) begin
                        hash_next = START_HASH;
                        fill_next = '0;
                        bits_next = '0;
                    end
                end
            end
            default: begin
                after_next = after_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            after_reg    <= AFTER_IDLE;
            fill_reg     <= '0;
            bits_reg     <= '0;
            round_reg    <= '0;
            emit_idx_reg <= '0;
            hash_reg     <= START_HASH;
        end else begin
            state_reg    <= state_next;
            after_reg    <= after_next;
            fill_reg     <= fill_next;
            bits_reg     <= bits_next;
            round_reg    <= round_next;
            emit_idx_reg <= emit_idx_next;
            hash_reg     <= hash_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg  <= work_next;
        sched_reg <= sched_next;
    end

endmodule

FILE: rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher: a byte transaction is taken from the command queue and absorbed into the block buffer.
// A full block runs 64 rounds on the single round unit, then one hash update.
// End of message pads one byte per cycle, except while a block compresses, then runs one or two compressions.
// The digest leaves as eight word transactions, one per cycle while m_ready is high.
// Input transactions are accepted while the four-entry command queue has room.
// Reset is synchronous and active low; the hash words return to their initial values at once.
module sha256_stream_hasher (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sha256_pkg::in_item_t  s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sha256_pkg::out_item_t m_item
);
    import sha256_pkg::*;

    q_push_t   q_push;
    q_status_t q_status;
    cmd_t      q_head;
    logic      q_pop;

    sha256_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .q_status (q_status),
        .q_push   (q_push)
    );

    sha256_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_push   (q_push),
        .q_pop    (q_pop),
        .q_head   (q_head),
        .q_status (q_status)
    );

    sha256_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .q_status (q_status),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

FILE: rtl/sha256_checker.sv
// Port-level checks for the SHA-256 stream hasher, bound to the top level.
// Depends on sha256_pkg and sha256_stream_hasher.
module sha256_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input sha256_pkg::in_item_t  s_item,
    input logic                  m_valid,
    input logic                  m_ready,
    input sha256_pkg::out_item_t m_item
);
    import sha256_pkg::*;

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
    else $error("Input transaction changed while stalled.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
    else $error("Result transaction changed while stalled.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_item.last_word |=>
            m_valid && (m_item.word_index == $past(m_item.word_index) + 3'd1))
    else $error("Digest words did not follow in order.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.last_word == (m_item.word_index == 3'd7)))
    else $error("Last word flag does not match the word index.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_item.last_word |=> !m_valid)
    else $error("Result transaction appeared right after the final digest word.");

endmodule

bind sha256_stream_hasher sha256_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
